@@ hw/rtl/msi_dm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msi_dm_pkg
// types and codes shared by the msi direct-mapped l1 cache
// ----------------------------------------------------------------------------
package msi_dm_pkg;

  localparam int TAG_W  = 16;
  localparam int WORD_W = 32;

  typedef enum logic [2:0] {
    CMD_READ            = 3'd0,
    CMD_WRITE           = 3'd1,
    CMD_FILL            = 3'd2,
    CMD_SNOOP_READ_MISS = 3'd3,
    CMD_SNOOP_WRITE_MISS = 3'd4,
    CMD_SNOOP_WRITE_HIT = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    COH_I = 2'd0,
    COH_S = 2'd1,
    COH_M = 2'd2
  } coh_t;

  typedef enum logic [1:0] {
    EV_NONE       = 2'd0,
    EV_READ_MISS  = 2'd1,
    EV_WRITE_HIT  = 2'd2,
    EV_WRITE_MISS = 2'd3
  } bus_ev_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_READ,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [WORD_W-1:0] word;
    logic [1:0]        coh;
  } line_t;

endpackage

@@ hw/rtl/msi_direct_mapped_l1_cache.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msi_direct_mapped_l1_cache
// direct-mapped write-through l1 line store with msi snooping
// ----------------------------------------------------------------------------
// Each beat on s_* is one local access or snoop and gives exactly one result
// beat on m_*. An accepted item is reduced to a line index by a reciprocal
// multiply step and a subtract step; the read step corrects the remainder
// and reads the line memory, and the update step writes the line and loads
// the output register. No new item is taken until the current one has left
// its update step; a result waiting on m_tready holds the current item in
// its update step. After reset a clearing pass walks every line of the line
// memory, during which s_tready stays low.
module msi_direct_mapped_l1_cache
  import msi_dm_pkg::*;
#(
  parameter int LINES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // address[15:0], data[47:16]
  input  logic [2:0]  s_tuser,   // command[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata    // read_data[31:0], hit[32], bus_event[34:33],
                                 // bus_address[50:35], bus_data[82:51], zero
);

  localparam int IW = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int RW = IW + 1;
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / LINES);

  state_t state, state_next;

  line_t mem [LINES];
  line_t ent_rd;
  line_t mem_wd;
  logic  mem_we;
  logic [IW-1:0] mem_wa;

  logic [IW-1:0] clr_idx;
  logic [2:0]    cmd;
  logic [15:0]   addr;
  logic [31:0]   data;
  logic [15:0]   quo;
  logic [RW-1:0] rem;
  logic [IW-1:0] idx;
  logic [IW-1:0] idx_rd;
  logic [48:0]   prod;
  logic [16:0]   diff;

  logic          line_hit;
  logic          upd_we;
  line_t         upd_wd;
  logic [31:0]   res_rdata;
  logic          res_hit;
  bus_ev_t       res_ev;
  logic [15:0]   res_baddr;
  logic [31:0]   res_bdata;
  logic          out_free;

  logic [31:0]   read_data;
  logic          hit;
  logic [1:0]    bus_event;
  logic [15:0]   bus_address;
  logic [31:0]   bus_data;

  assign prod     = 49'(addr) * 49'(RECIP);
  assign diff     = 17'(addr) - 17'(quo * 16'(LINES));
  assign idx_rd   = (rem >= RW'(LINES)) ? IW'(rem - RW'(LINES)) : IW'(rem);
  assign out_free = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_idx == IW'(LINES - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (s_tvalid) state_next = ST_MUL;
      ST_MUL:    state_next = ST_SUB;
      ST_SUB:    state_next = ST_READ;
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready = 1'b0;
    mem_we   = 1'b0;
    mem_wa   = idx;
    mem_wd   = upd_wd;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_idx;
        mem_wd = '{tag: '0, word: '0, coh: COH_I};
      end
      ST_IDLE:   s_tready = 1'b1;
      ST_UPDATE: mem_we = upd_we && out_free;
      default: ;
    endcase
  end

  // line update and result
  always_comb begin
    line_hit  = (ent_rd.tag == addr) && (ent_rd.coh == COH_S || ent_rd.coh == COH_M);
    upd_we    = 1'b0;
    upd_wd    = ent_rd;
    res_rdata = '1;
    res_hit   = 1'b0;
    res_ev    = EV_NONE;
    res_baddr = '0;
    res_bdata = '0;
    case (cmd)
      CMD_READ: begin
        if (line_hit) begin
          res_rdata = ent_rd.word;
          res_hit   = 1'b1;
        end else begin
          res_ev    = EV_READ_MISS;
          res_baddr = addr;
        end
      end
      CMD_WRITE: begin
        res_hit   = line_hit;
        res_ev    = line_hit ? EV_WRITE_HIT : EV_WRITE_MISS;
        res_baddr = addr;
        res_bdata = data;
        upd_we    = 1'b1;
        upd_wd    = '{tag: addr, word: data, coh: COH_M};
      end
      CMD_FILL: begin
        res_rdata = data;
        upd_we    = 1'b1;
        upd_wd    = '{tag: addr, word: data, coh: COH_S};
      end
      CMD_SNOOP_READ_MISS: begin
        if (ent_rd.tag == addr && ent_rd.coh == COH_M) begin
          upd_we     = 1'b1;
          upd_wd.coh = COH_S;
        end
      end
      CMD_SNOOP_WRITE_MISS, CMD_SNOOP_WRITE_HIT: begin
        if (ent_rd.tag == addr) begin
          upd_we     = 1'b1;
          upd_wd.coh = COH_I;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_idx  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (state == ST_UPDATE && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd  <= s_tuser;
      addr <= s_tdata[15:0];
      data <= s_tdata[47:16];
    end
    if (state == ST_MUL) quo <= prod[47:32];
    if (state == ST_SUB) rem <= RW'(diff);
    if (state == ST_READ) idx <= idx_rd;
    if (state == ST_UPDATE && out_free) begin
      read_data   <= res_rdata;
      hit         <= res_hit;
      bus_event   <= res_ev;
      bus_address <= res_baddr;
      bus_data    <= res_bdata;
    end
  end

  // line memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (state == ST_READ) ent_rd <= mem[idx_rd];
  end

  assign m_tdata = {5'd0, bus_data, bus_address, bus_event, hit, read_data};

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !s_tready)
    else $error("input taken during clearing pass");

  a_accept_starts_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_MUL)
    else $error("accepted item did not start");

  a_update_stalls: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPDATE && m_tvalid && !m_tready |=> state == ST_UPDATE && m_tvalid)
    else $error("result overwritten while output full");

  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_UPDATE)
    else $error("result appeared outside update");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPDATE |-> RW'(idx) < RW'(LINES))
    else $error("line index out of range");
`endif

endmodule
